FILE: design/worker_count_planner_defines.svh
// ----------------------------------------------------------------------------
// Worker count planner assertion macros
// Shared concurrent-check wrappers, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WORKER_COUNT_PLANNER_DEFINES_SVH
`define WORKER_COUNT_PLANNER_DEFINES_SVH

// same-cycle implication
`define WCP_ASSERT_HOLDS(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("worker count planner check failed");

// next-cycle implication
`define WCP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("worker count planner check failed");

`endif

FILE: design/wcp_pkg.sv
// ----------------------------------------------------------------------------
// Worker count planner package
// Widths, codes, control word layout and the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package wcp_pkg;

   // default worker limit
   localparam int WORKER_LIMIT_DEFAULT = 1024;

   // field widths
   localparam int RATE_W      = 32;
   localparam int TASK_W      = 32;
   localparam int QUEUE_W     = 20;
   localparam int RT_W        = 32;
   localparam int HOLD_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   // fixed point: rates 12 frac, task time 24 frac, recover time 16 frac
   localparam int Q_SHIFT     = 28;
   localparam int QUOT_W      = QUEUE_W + Q_SHIFT;
   localparam int DIFF_W      = RATE_W + 2;
   localparam int MAG_W       = QUOT_W + 2;
   localparam int PROD_W      = MAG_W + TASK_W;
   localparam int SCALE_SHIFT = 36;
   localparam int SCALED_W    = PROD_W - SCALE_SHIFT;

   localparam logic [RT_W-1:0] RECOVER_TIME_RESET = 32'h0001_0000;

   // sequencer sizing
   localparam int PC_W   = 4;
   localparam int LOOP_W = 6;

   // request opcodes
   localparam logic OPC_TICK = 1'b0;
   localparam logic OPC_PLAN = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_OFF = 3'd4;

   typedef enum logic [1:0] {
      ACT_INCREASE = 2'd0,
      ACT_DECREASE = 2'd1,
      ACT_RECOVER  = 2'd2,
      ACT_NONE     = 2'd3
   } wcp_action_type;

   // datapath operations
   typedef enum logic [2:0] {
      OP_NOP      = 3'd0,
      OP_DIV_INIT = 3'd1,
      OP_DIV_STEP = 3'd2,
      OP_SUM      = 3'd3,
      OP_MUL_STEP = 3'd4,
      OP_SCALE    = 3'd5,
      OP_CLAMP    = 3'd6,
      OP_COMMIT   = 3'd7
   } wcp_op_type;

   // jump conditions
   typedef enum logic [2:0] {
      J_NEXT        = 3'd0,
      J_ALWAYS      = 3'd1,
      J_NO_START    = 3'd2,
      J_NOT_RECOVER = 3'd3,
      J_LOOP        = 3'd4,
      J_OUT_BUSY    = 3'd5
   } wcp_cond_type;

   // program addresses
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] PC_DIV_INIT = 4'd1;
   localparam logic [PC_W-1:0] PC_DIV_LOOP = 4'd2;
   localparam logic [PC_W-1:0] PC_SUM      = 4'd3;
   localparam logic [PC_W-1:0] PC_MUL_LOOP = 4'd4;
   localparam logic [PC_W-1:0] PC_SCALE    = 4'd5;
   localparam logic [PC_W-1:0] PC_CLAMP    = 4'd6;
   localparam logic [PC_W-1:0] PC_WAIT     = 4'd7;
   localparam logic [PC_W-1:0] PC_COMMIT   = 4'd8;

   localparam logic [LOOP_W-1:0] DIV_COUNT = LOOP_W'(QUOT_W - 1);
   localparam logic [LOOP_W-1:0] MUL_COUNT = LOOP_W'(TASK_W - 1);

   typedef struct packed {
      wcp_op_type        op;
      wcp_cond_type      cond;
      logic [PC_W-1:0]   target;
      logic              load_cnt;
      logic [LOOP_W-1:0] count;
   } wcp_uword_type;

   // sequencer to datapath and top
   typedef struct packed {
      wcp_op_type op;
      logic       idle;
   } wcp_ctrl_type;

   // conditions fed back to the sequencer
   typedef struct packed {
      logic start;
      logic recover;
      logic out_busy;
   } wcp_status_type;

   // microcode ROM
   function automatic wcp_uword_type wcp_ucode(input logic [PC_W-1:0] addr);
      wcp_uword_type w;
      w = '{op: OP_NOP, cond: J_ALWAYS, target: PC_IDLE, load_cnt: 1'b0, count: '0};
      unique case (addr)
         PC_IDLE:     w = '{op: OP_NOP, cond: J_NO_START, target: PC_IDLE,
                            load_cnt: 1'b0, count: '0};
         PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: J_NOT_RECOVER, target: PC_SUM,
                            load_cnt: 1'b1, count: DIV_COUNT};
         PC_DIV_LOOP: w = '{op: OP_DIV_STEP, cond: J_LOOP, target: PC_DIV_LOOP,
                            load_cnt: 1'b0, count: '0};
         PC_SUM:      w = '{op: OP_SUM, cond: J_NEXT, target: PC_IDLE,
                            load_cnt: 1'b1, count: MUL_COUNT};
         PC_MUL_LOOP: w = '{op: OP_MUL_STEP, cond: J_LOOP, target: PC_MUL_LOOP,
                            load_cnt: 1'b0, count: '0};
         PC_SCALE:    w = '{op: OP_SCALE, cond: J_NEXT, target: PC_IDLE,
                            load_cnt: 1'b0, count: '0};
         PC_CLAMP:    w = '{op: OP_CLAMP, cond: J_NEXT, target: PC_IDLE,
                            load_cnt: 1'b0, count: '0};
         PC_WAIT:     w = '{op: OP_NOP, cond: J_OUT_BUSY, target: PC_WAIT,
                            load_cnt: 1'b0, count: '0};
         PC_COMMIT:   w = '{op: OP_COMMIT, cond: J_ALWAYS, target: PC_IDLE,
                            load_cnt: 1'b0, count: '0};
         default:     w = '{op: OP_NOP, cond: J_ALWAYS, target: PC_IDLE,
                            load_cnt: 1'b0, count: '0};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

FILE: design/wcp_sequencer.sv
// ----------------------------------------------------------------------------
// Worker count planner sequencer
// Step counter, loop counter and jump logic over the microcode ROM.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_sequencer (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wcp_pkg::wcp_status_type status,
   output wcp_pkg::wcp_ctrl_type        ctrl
);

   logic [wcp_pkg::PC_W-1:0]   pc_ff;
   logic [wcp_pkg::PC_W-1:0]   pc_in;
   logic [wcp_pkg::LOOP_W-1:0] cnt_ff;
   logic [wcp_pkg::LOOP_W-1:0] cnt_in;
   wcp_pkg::wcp_uword_type     word;
   logic                       take;

   // fetch and branch
   always_comb begin
      word   = wcp_pkg::wcp_ucode(pc_ff);
      take   = 1'b0;
      cnt_in = cnt_ff;
      unique case (word.cond)
         wcp_pkg::J_NEXT:        take = 1'b0;
         wcp_pkg::J_ALWAYS:      take = 1'b1;
         wcp_pkg::J_NO_START:    take = !status.start;
         wcp_pkg::J_NOT_RECOVER: take = !status.recover;
         wcp_pkg::J_LOOP: begin
            take = (cnt_ff != '0);
            if (take) begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         wcp_pkg::J_OUT_BUSY:    take = status.out_busy;
         default:                take = 1'b0;
      endcase
      if (word.load_cnt) begin
         cnt_in = word.count;
      end
      pc_in = take ? word.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= wcp_pkg::PC_IDLE;
         cnt_ff <= '0;
      end else begin
         pc_ff  <= pc_in;
         cnt_ff <= cnt_in;
      end
   end

   assign ctrl.op   = word.op;
   assign ctrl.idle = (pc_ff == wcp_pkg::PC_IDLE);

endmodule

`default_nettype wire

FILE: design/wcp_datapath.sv
// ----------------------------------------------------------------------------
// Worker count planner datapath
// Config registers, kept state, serial divider, serial multiplier, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module wcp_datapath #(
   parameter int WORKER_LIMIT = wcp_pkg::WORKER_LIMIT_DEFAULT,
   localparam int CW = $clog2(WORKER_LIMIT)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire wcp_pkg::wcp_ctrl_type             ctrl,
   input  wire logic                              start,
   input  wire logic                              tick,
   input  wire logic [1:0]                        req_action,
   input  wire logic [wcp_pkg::RATE_W-1:0]        req_throughput,
   input  wire logic [wcp_pkg::RATE_W-1:0]        req_arrival_rate,
   input  wire logic [wcp_pkg::TASK_W-1:0]        req_task_time,
   input  wire logic [wcp_pkg::QUEUE_W-1:0]       req_queue_length,
   input  wire logic                              csr_wen,
   input  wire logic [wcp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [wcp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output logic                                   recover,
   output logic signed [CW:0]                     res_change,
   output logic [CW-1:0]                          res_count,
   output logic                                   res_held
);

   localparam int DW = CW + 3;
   localparam logic [wcp_pkg::SCALED_W-1:0] SAT_LIM =
      wcp_pkg::SCALED_W'(2 * WORKER_LIMIT);
   localparam logic signed [DW-1:0] DELTA_ONE = DW'(1);

   // config registers
   logic [CW-1:0]              min_ff;
   logic [CW-1:0]              max_ff;
   logic [wcp_pkg::RT_W-1:0]   recover_ff;
   logic [wcp_pkg::HOLD_W-1:0] hold_ff;

   // kept state
   logic [CW-1:0]              total_ff;
   logic [CW-1:0]              total_in;
   logic [wcp_pkg::HOLD_W-1:0] ticks_ff;
   logic [wcp_pkg::HOLD_W-1:0] ticks_in;

   // request operands
   wcp_pkg::wcp_action_type    action_ff;
   logic [wcp_pkg::DIFF_W-1:0] d_ff;
   logic [wcp_pkg::TASK_W-1:0] task_ff;
   logic [wcp_pkg::QUEUE_W-1:0] queue_ff;

   // arithmetic registers
   logic [wcp_pkg::QUOT_W-1:0] num_ff;
   logic [wcp_pkg::QUOT_W-1:0] num_in;
   logic [wcp_pkg::RT_W-1:0]   rem_ff;
   logic [wcp_pkg::RT_W-1:0]   rem_in;
   logic [wcp_pkg::MAG_W-1:0]  mag_ff;
   logic [wcp_pkg::MAG_W-1:0]  mag_in;
   logic                       neg_ff;
   logic                       neg_in;
   logic [wcp_pkg::PROD_W-1:0] prod_ff;
   logic [wcp_pkg::PROD_W-1:0] prod_in;
   logic signed [DW-1:0]       delta_ff;
   logic signed [DW-1:0]       delta_in;
   logic [CW-1:0]              want_ff;
   logic [CW-1:0]              want_in;

   // combinational intermediates
   logic [wcp_pkg::RT_W-1:0]     rt_eff;
   logic [wcp_pkg::RT_W:0]       div_shift;
   logic                         div_ge;
   logic [wcp_pkg::MAG_W-1:0]    sum_val;
   logic [wcp_pkg::MAG_W:0]      acc_sum;
   logic [wcp_pkg::MAG_W:0]      acc_val;
   logic [wcp_pkg::SCALED_W-1:0] scaled;
   logic [wcp_pkg::SCALED_W-1:0] scaled_sat;
   logic signed [DW-1:0]         sdelta;
   logic signed [DW-1:0]         want_raw;
   logic signed [DW-1:0]         want_lo;
   logic signed [DW-1:0]         min_x;
   logic signed [DW-1:0]         max_x;
   logic                         changed;
   logic                         blocked;
   logic                         apply;

   assign recover = (action_ff == wcp_pkg::ACT_RECOVER);
   assign rt_eff  = (recover_ff == '0) ? wcp_pkg::RT_W'(1) : recover_ff;

   // restoring divider step: queue * 2^28 / recover_time
   always_comb begin
      div_shift = {rem_ff, num_ff[wcp_pkg::QUOT_W-1]};
      div_ge    = (div_shift >= {1'b0, rt_eff});
      num_in    = num_ff;
      rem_in    = rem_ff;
      if (ctrl.op == wcp_pkg::OP_DIV_INIT) begin
         num_in = {queue_ff, {wcp_pkg::Q_SHIFT{1'b0}}};
         rem_in = '0;
      end else if (ctrl.op == wcp_pkg::OP_DIV_STEP) begin
         num_in = {num_ff[wcp_pkg::QUOT_W-2:0], div_ge};
         rem_in = div_ge ? wcp_pkg::RT_W'(div_shift - {1'b0, rt_eff})
                         : div_shift[wcp_pkg::RT_W-1:0];
      end
   end

   // signed sum and its magnitude, then shift-add multiply by task time
   always_comb begin
      sum_val = (recover ? {2'b00, num_ff} : '0)
              + {{(wcp_pkg::MAG_W - wcp_pkg::DIFF_W){d_ff[wcp_pkg::DIFF_W-1]}}, d_ff};
      acc_sum = {1'b0, prod_ff[wcp_pkg::PROD_W-1:wcp_pkg::TASK_W]} + {1'b0, mag_ff};
      acc_val = prod_ff[0] ? acc_sum
                           : {1'b0, prod_ff[wcp_pkg::PROD_W-1:wcp_pkg::TASK_W]};
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      prod_in = prod_ff;
      if (ctrl.op == wcp_pkg::OP_SUM) begin
         neg_in  = sum_val[wcp_pkg::MAG_W-1];
         mag_in  = sum_val[wcp_pkg::MAG_W-1] ? (~sum_val + 1'b1) : sum_val;
         prod_in = {{wcp_pkg::MAG_W{1'b0}}, task_ff};
      end else if (ctrl.op == wcp_pkg::OP_MUL_STEP) begin
         prod_in = {acc_val, prod_ff[wcp_pkg::TASK_W-1:1]};
      end
   end

   // scale down, saturate, apply action rule
   always_comb begin
      scaled     = prod_ff[wcp_pkg::PROD_W-1:wcp_pkg::SCALE_SHIFT];
      scaled_sat = (scaled > SAT_LIM) ? SAT_LIM : scaled;
      sdelta     = neg_ff ? -$signed(scaled_sat[DW-1:0]) : $signed(scaled_sat[DW-1:0]);
      delta_in   = delta_ff;
      if (ctrl.op == wcp_pkg::OP_SCALE) begin
         case (action_ff)
            wcp_pkg::ACT_INCREASE: delta_in = (sdelta < DELTA_ONE) ? DELTA_ONE : sdelta;
            wcp_pkg::ACT_DECREASE: delta_in = sdelta;
            wcp_pkg::ACT_RECOVER:  delta_in = sdelta;
            default:               delta_in = '0;
         endcase
      end
   end

   // clamp: lower bound first, upper bound wins
   always_comb begin
      min_x    = $signed({{(DW - CW){1'b0}}, min_ff});
      max_x    = $signed({{(DW - CW){1'b0}}, max_ff});
      want_raw = $signed({{(DW - CW){1'b0}}, total_ff}) + delta_ff;
      want_lo  = (want_raw < min_x) ? min_x : want_raw;
      want_in  = want_ff;
      if (ctrl.op == wcp_pkg::OP_CLAMP) begin
         want_in = (want_lo > max_x) ? max_ff : want_lo[CW-1:0];
      end
   end

   // commit decision
   assign changed    = (want_ff != total_ff);
   assign blocked    = changed && (ticks_ff < hold_ff);
   assign apply      = (ctrl.op == wcp_pkg::OP_COMMIT) && changed && !blocked;
   assign res_change = (changed && !blocked)
                     ? $signed({1'b0, want_ff} - {1'b0, total_ff}) : '0;
   assign res_count  = (changed && !blocked) ? want_ff : total_ff;
   assign res_held   = blocked;

   // kept state updates
   always_comb begin
      total_in = total_ff;
      ticks_in = ticks_ff;
      if (apply) begin
         total_in = want_ff;
         ticks_in = '0;
      end else if (tick && (ticks_ff != '1)) begin
         ticks_in = ticks_ff + 1'b1;
      end
      if (csr_wen && (csr_index == wcp_pkg::CSR_START)) begin
         total_in = csr_wdata[CW-1:0];
      end
   end

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff     <= CW'(1);
         max_ff     <= CW'(WORKER_LIMIT - 1);
         recover_ff <= wcp_pkg::RECOVER_TIME_RESET;
         hold_ff    <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            wcp_pkg::CSR_MIN:      min_ff     <= csr_wdata[CW-1:0];
            wcp_pkg::CSR_MAX:      max_ff     <= csr_wdata[CW-1:0];
            wcp_pkg::CSR_RECOVER:  recover_ff <= csr_wdata[wcp_pkg::RT_W-1:0];
            wcp_pkg::CSR_HOLD_OFF: hold_ff    <= csr_wdata[wcp_pkg::HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= CW'(1);
         ticks_ff <= '0;
      end else begin
         total_ff <= total_in;
         ticks_ff <= ticks_in;
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (start) begin
         action_ff <= wcp_pkg::wcp_action_type'(req_action);
         d_ff      <= {2'b00, req_arrival_rate} - {2'b00, req_throughput};
         task_ff   <= req_task_time;
         queue_ff  <= req_queue_length;
      end
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      prod_ff  <= prod_in;
      delta_ff <= delta_in;
      want_ff  <= want_in;
   end

endmodule

`default_nettype wire

FILE: design/worker_count_planner.sv
// Plan request: divide init, divider loop (recover only), sum, 32-step shift-add multiply,
// scale, clamp, wait while the output is stalled, commit; the next request is accepted once
// the sequencer is back idle after the result is registered. The divider is 48-step restoring.
// Tick requests are accepted whenever the sequencer is idle.
// Synchronous active-high reset returns registers to their reset values and the
// sequencer to its idle step.
// ----------------------------------------------------------------------------
// Worker count planner
// Top level: handshakes, result register, sequencer and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "worker_count_planner_defines.svh"

module worker_count_planner #(
   parameter int WORKER_LIMIT = wcp_pkg::WORKER_LIMIT_DEFAULT,
   localparam int CW = $clog2(WORKER_LIMIT)
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_opcode,
   input  wire logic [1:0]                     req_action,
   input  wire logic [wcp_pkg::RATE_W-1:0]     req_throughput,
   input  wire logic [wcp_pkg::RATE_W-1:0]     req_arrival_rate,
   input  wire logic [wcp_pkg::TASK_W-1:0]     req_task_time,
   input  wire logic [wcp_pkg::QUEUE_W-1:0]    req_queue_length,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [CW:0]                  rsp_worker_change,
   output logic [CW-1:0]                       rsp_worker_count,
   output logic                                rsp_held_off,
   input  wire logic                           csr_wen,
   input  wire logic [wcp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [wcp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wcp_pkg::wcp_ctrl_type   ctrl;
   wcp_pkg::wcp_status_type status;
   logic                    accept;
   logic                    start;
   logic                    tick;
   logic                    recover;
   logic signed [CW:0]      res_change;
   logic [CW-1:0]           res_count;
   logic                    res_held;

   logic                    rsp_valid_ff;
   logic signed [CW:0]      rsp_worker_change_ff;
   logic [CW-1:0]           rsp_worker_count_ff;
   logic                    rsp_held_off_ff;

   // request handshake
   assign req_stall = !ctrl.idle;
   assign accept    = req_valid && ctrl.idle;
   assign start     = accept && (req_opcode == wcp_pkg::OPC_PLAN);
   assign tick      = accept && (req_opcode == wcp_pkg::OPC_TICK);

   assign status.start    = start;
   assign status.recover  = recover;
   assign status.out_busy = rsp_valid_ff && rsp_stall;

   wcp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   wcp_datapath #(
      .WORKER_LIMIT (WORKER_LIMIT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .start            (start),
      .tick             (tick),
      .req_action       (req_action),
      .req_throughput   (req_throughput),
      .req_arrival_rate (req_arrival_rate),
      .req_task_time    (req_task_time),
      .req_queue_length (req_queue_length),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .recover          (recover),
      .res_change       (res_change),
      .res_count        (res_count),
      .res_held         (res_held)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op == wcp_pkg::OP_COMMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == wcp_pkg::OP_COMMIT) begin
         rsp_worker_change_ff <= res_change;
         rsp_worker_count_ff  <= res_count;
         rsp_held_off_ff      <= res_held;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_worker_change = rsp_worker_change_ff;
   assign rsp_worker_count  = rsp_worker_count_ff;
   assign rsp_held_off      = rsp_held_off_ff;

   // checks
   `WCP_ASSERT_HOLDS(a_commit_out_free, ctrl.op == wcp_pkg::OP_COMMIT, !(rsp_valid_ff && rsp_stall))
   `WCP_ASSERT_NEXT(a_commit_to_idle, ctrl.op == wcp_pkg::OP_COMMIT, ctrl.idle)
   `WCP_ASSERT_HOLDS(a_held_no_change, rsp_valid_ff && rsp_held_off_ff, rsp_worker_change_ff == '0)
   `WCP_ASSERT_HOLDS(a_rsp_from_commit, $rose(rsp_valid_ff), $past(ctrl.op == wcp_pkg::OP_COMMIT))

endmodule

`default_nettype wire

FILE: tb/worker_count_planner_tb.sv
// ----------------------------------------------------------------------------
// Worker count planner testbench
// Drives tick and plan requests through the valid/stall channels, programs the
// control registers between phases and checks every plan result against an
// in-bench model of the worker count, the tick counter and the hold-off rule.
// ----------------------------------------------------------------------------
module worker_count_planner_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wcp_pkg::*;

   localparam int WORKER_LIMIT  = WORKER_LIMIT_DEFAULT;
   localparam int CW            = $clog2(WORKER_LIMIT);
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int DRAIN_TAIL    = 100;
   localparam int RANDOM_PHASES = 14;
   localparam int PHASE_ITEMS   = 100;
   localparam int MAX_PRINTED   = 100;

   // indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct {
      logic               opcode;
      wcp_action_type     action;
      logic [RATE_W-1:0]  throughput;
      logic [RATE_W-1:0]  arrival;
      logic [TASK_W-1:0]  svc_time;
      logic [QUEUE_W-1:0] queue_len;
   } plan_request_type;

   typedef struct {
      logic signed [CW:0] change;
      logic [CW-1:0]      count;
      logic               held;
   } plan_outcome_type;

   // Worker count model plus the queue of outcomes still owed by the block
   class worker_plan_board;
      logic [CW-1:0]     start_workers;
      logic [CW-1:0]     floor_count;
      logic [CW-1:0]     ceiling_count;
      logic [CW-1:0]     worker_total;
      logic [RT_W-1:0]   recover_time;
      logic [HOLD_W-1:0] hold_off;
      logic [HOLD_W-1:0] ticks_since_change;
      plan_outcome_type  pending_outcomes[$];
      int mismatches;
      int results_seen;
      int plans_seen;
      int ticks_seen;
      int writes_seen;
      int held_seen;

      function new();
         start_workers      = CW'(1);
         floor_count        = CW'(1);
         ceiling_count      = CW'(WORKER_LIMIT - 1);
         worker_total       = CW'(1);
         recover_time       = RECOVER_TIME_RESET;
         hold_off           = '0;
         ticks_since_change = '0;
         mismatches   = 0;
         results_seen = 0;
         plans_seen   = 0;
         ticks_seen   = 0;
         writes_seen  = 0;
         held_seen    = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         writes_seen++;
         case (idx)
            CSR_START: begin
               start_workers = data[CW-1:0];
               worker_total  = data[CW-1:0];
            end
            CSR_MIN:      floor_count   = data[CW-1:0];
            CSR_MAX:      ceiling_count = data[CW-1:0];
            CSR_RECOVER:  recover_time  = data[RT_W-1:0];
            CSR_HOLD_OFF: hold_off      = data[HOLD_W-1:0];
            default: ;
         endcase
      endfunction

      // trunc(rate * svc / 2^36), magnitude capped at twice the worker limit
      function longint scale_rate(longint rate, logic [TASK_W-1:0] svc);
         logic [127:0] mag;
         logic [127:0] prod;
         longint       r;
         mag  = (rate < 0) ? 128'(-rate) : 128'(rate);
         prod = (mag * 128'(svc)) >> SCALE_SHIFT;
         r    = (prod > 128'(2 * WORKER_LIMIT)) ? longint'(2 * WORKER_LIMIT) : longint'(prod);
         return (rate < 0) ? -r : r;
      endfunction

      function void note_request(plan_request_type r);
         longint           rate_gap;
         longint           queue_rate;
         longint           delta;
         longint           want;
         longint           diff;
         logic [63:0]      rt;
         plan_outcome_type o;
         if (r.opcode == OPC_TICK) begin
            ticks_seen++;
            if (ticks_since_change != '1) ticks_since_change++;
            return;
         end
         plans_seen++;
         rate_gap = longint'({32'b0, r.arrival}) - longint'({32'b0, r.throughput});
         delta = 0;
         case (r.action)
            ACT_INCREASE: begin
               delta = scale_rate(rate_gap, r.svc_time);
               if (delta < 1) delta = 1;
            end
            ACT_DECREASE: delta = scale_rate(rate_gap, r.svc_time);
            ACT_RECOVER: begin
               // a zero recover time divides by one
               rt = (recover_time == '0) ? 64'd1 : {32'b0, recover_time};
               queue_rate = longint'(({44'b0, r.queue_len} << Q_SHIFT) / rt);
               delta = scale_rate(rate_gap + queue_rate, r.svc_time);
            end
            default: delta = 0;
         endcase
         // lower bound first, so the upper bound wins when they cross
         want = longint'({54'b0, worker_total}) + delta;
         if (want < longint'({54'b0, floor_count})) want = longint'({54'b0, floor_count});
         if (want > longint'({54'b0, ceiling_count})) want = longint'({54'b0, ceiling_count});
         diff = want - longint'({54'b0, worker_total});
         o.held = 1'b0;
         if (diff != 0) begin
            if (ticks_since_change < hold_off) begin
               o.held = 1'b1;
               diff = 0;
               held_seen++;
            end else begin
               worker_total       = want[CW-1:0];
               ticks_since_change = '0;
            end
         end
         o.change = diff[CW:0];
         o.count  = worker_total;
         pending_outcomes.push_back(o);
      endfunction

      task report(string msg);
         if (mismatches < MAX_PRINTED) $display("MISMATCH: %s", msg);
         mismatches++;
      endtask

      task check_result(plan_outcome_type got);
         plan_outcome_type want_o;
         results_seen++;
         if (pending_outcomes.size() == 0) begin
            report($sformatf("result with nothing pending: change=%0d count=%0d held=%0b",
                             got.change, got.count, got.held));
            return;
         end
         want_o = pending_outcomes.pop_front();
         if (got.change !== want_o.change)
            report($sformatf("result %0d worker_change got %0d want %0d",
                             results_seen, got.change, want_o.change));
         if (got.count !== want_o.count)
            report($sformatf("result %0d worker_count got %0d want %0d",
                             results_seen, got.count, want_o.count));
         if (got.held !== want_o.held)
            report($sformatf("result %0d held_off got %0b want %0b",
                             results_seen, got.held, want_o.held));
      endtask

      function int pending();
         return pending_outcomes.size();
      endfunction

      task report_leftovers();
         if (pending_outcomes.size() != 0)
            report($sformatf("%0d expected results never arrived", pending_outcomes.size()));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_stall;
   logic                    req_opcode;
   logic [1:0]              req_action;
   logic [RATE_W-1:0]       req_throughput;
   logic [RATE_W-1:0]       req_arrival_rate;
   logic [TASK_W-1:0]       req_task_time;
   logic [QUEUE_W-1:0]      req_queue_length;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic signed [CW:0]      rsp_worker_change;
   logic [CW-1:0]           rsp_worker_count;
   logic                    rsp_held_off;
   logic                    csr_wen;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   worker_plan_board plan_board = new();
   int stall_mode;
   bit sender_idles;
   int cycle_count;

   worker_count_planner #(.WORKER_LIMIT(WORKER_LIMIT)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_action        (req_action),
      .req_throughput    (req_throughput),
      .req_arrival_rate  (req_arrival_rate),
      .req_task_time     (req_task_time),
      .req_queue_length  (req_queue_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_worker_change (rsp_worker_change),
      .rsp_worker_count  (rsp_worker_count),
      .rsp_held_off      (rsp_held_off),
      .csr_wen           (csr_wen),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, plan_board.pending());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // both handshakes sampled at the rising edge
   always @(posedge clock) begin : monitor
      plan_outcome_type got;
      plan_request_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.change = rsp_worker_change;
            got.count  = rsp_worker_count;
            got.held   = rsp_held_off;
            plan_board.check_result(got);
         end
         if (req_valid && !req_stall) begin
            seen.opcode     = req_opcode;
            seen.action     = wcp_action_type'(req_action);
            seen.throughput = req_throughput;
            seen.arrival    = req_arrival_rate;
            seen.svc_time   = req_task_time;
            seen.queue_len  = req_queue_length;
            plan_board.note_request(seen);
         end
      end
   end

   // receiver stall bursts, started at a rate set per phase
   initial begin
      int burst;
      burst = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (stall_mode != 0 &&
                      $urandom_range(0, (stall_mode == 1) ? 15 : 3) == 0) begin
            burst = $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   // 10-bit register value with random or clear upper bits
   function automatic logic [CSR_DATA_W-1:0] with_garbage(logic [CW-1:0] v);
      logic [CSR_DATA_W-1:0] w;
      w = $urandom();
      if ($urandom_range(0, 1) == 0) w = '0;
      w[CW-1:0] = v;
      return w;
   endfunction

   function automatic plan_request_type random_request(bit is_plan, bit wild);
      plan_request_type r;
      int offset;
      int arr;
      r.opcode = is_plan ? OPC_PLAN : OPC_TICK;
      r.action = wcp_action_type'($urandom_range(0, 3));
      if (wild) begin
         r.throughput = pick_word();
         r.arrival    = pick_word();
         r.svc_time   = pick_word();
         case ($urandom_range(0, 2))
            0:       r.queue_len = '0;
            1:       r.queue_len = '1;
            default: r.queue_len = QUEUE_W'($urandom());
         endcase
      end else begin
         // rates near each other, service time up to a few seconds
         r.throughput = $urandom_range(0, 1 << 22);
         offset = $urandom_range(0, 1 << 17) - (1 << 16);
         arr = int'(r.throughput) + offset;
         r.arrival  = (arr < 0) ? '0 : RATE_W'(arr);
         r.svc_time = $urandom_range(0, 1 << 26);
         r.queue_len = ($urandom_range(0, 3) == 0) ? QUEUE_W'($urandom_range(0, 4095))
                                                    : QUEUE_W'($urandom_range(0, 31));
      end
      return r;
   endfunction

   task send_request(input plan_request_type r);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        <= 1'b1;
      req_opcode       <= r.opcode;
      req_action       <= r.action;
      req_throughput   <= r.throughput;
      req_arrival_rate <= r.arrival;
      req_task_time    <= r.svc_time;
      req_queue_length <= r.queue_len;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task send_plan(input wcp_action_type a, input logic [RATE_W-1:0] thr,
                  input logic [RATE_W-1:0] arr, input logic [TASK_W-1:0] svc,
                  input logic [QUEUE_W-1:0] q);
      plan_request_type r;
      r.opcode     = OPC_PLAN;
      r.action     = a;
      r.throughput = thr;
      r.arrival    = arr;
      r.svc_time   = svc;
      r.queue_len  = q;
      send_request(r);
   endtask

   task send_tick();
      plan_request_type r;
      r = random_request(1'b0, 1'b1);
      send_request(r);
   endtask

   // stop sending and let every owed result and any trailing tick finish
   task drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (plan_board.pending() != 0) @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      plan_board.write_reg(idx, data);
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      int phase;
      int sent;
      int k;
      int tick_run_max;
      int min_v;
      int max_v;
      int start_v;
      int idx;
      logic [31:0] hold_v;
      logic [31:0] rt_v;
      bit last_phase;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_opcode       = OPC_TICK;
      req_action       = ACT_INCREASE;
      req_throughput   = '0;
      req_arrival_rate = '0;
      req_task_time    = '0;
      req_queue_length = '0;
      csr_wen          = 1'b0;
      csr_index        = CSR_START;
      csr_wdata        = '0;
      stall_mode       = 0;
      sender_idles     = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings, one worker
      send_plan(ACT_NONE, '0, '0, '0, '0);
      // equal rates still add one worker
      send_plan(ACT_INCREASE, 32'h0010_0000, 32'h0010_0000, 32'h0100_0000, '0);
      send_plan(ACT_INCREASE, '1, '0, '1, '0);
      // largest growth saturates at the upper bound
      send_plan(ACT_INCREASE, '0, '1, '1, '0);
      send_plan(ACT_DECREASE, '1, '0, '1, '0);
      // decrease with arrivals above throughput grows the count
      send_plan(ACT_DECREASE, 32'h0001_0000, 32'h0001_4000, 32'h0100_0000, '0);
      send_plan(ACT_RECOVER, '0, '0, 32'h0100_0000, '1);
      send_plan(ACT_RECOVER, '1, '0, '1, '0);
      // zero service time
      send_plan(ACT_INCREASE, '0, '1, '0, '0);
      send_tick();

      // hold-off: suppressed, then allowed after enough ticks
      drain_results();
      csr_write(CSR_HOLD_OFF, 32'd3);
      send_plan(ACT_INCREASE, '0, 32'h0000_4000, 32'h0100_0000, '0);
      repeat (3) send_tick();
      send_plan(ACT_INCREASE, '0, 32'h0000_4000, 32'h0100_0000, '0);
      send_plan(ACT_NONE, '0, '1, '1, '1);

      // start write keeps the tick count
      repeat (3) send_tick();
      drain_results();
      csr_write(CSR_START, 32'd512);
      send_plan(ACT_INCREASE, '0, 32'h0000_2000, 32'h0100_0000, '0);

      // zero recover time acts as one
      drain_results();
      csr_write(CSR_RECOVER, '0);
      csr_write(CSR_HOLD_OFF, '0);
      send_plan(ACT_RECOVER, '0, '0, 32'h0100_0000, 20'd1);

      // crossed bounds: the maximum wins
      drain_results();
      csr_write(CSR_MIN, 32'd900);
      csr_write(CSR_MAX, 32'd100);
      send_plan(ACT_NONE, '0, '0, '0, '0);

      // writes to unused indexes change nothing
      drain_results();
      for (idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++)
         csr_write(CSR_IDX_W'(idx), $urandom());
      csr_write(CSR_MIN, '0);
      csr_write(CSR_MAX, '0);
      send_plan(ACT_INCREASE, '0, '1, '1, '0);

      // largest hold-off blocks every change
      drain_results();
      csr_write(CSR_MAX, 32'd1023);
      csr_write(CSR_HOLD_OFF, '1);
      csr_write(CSR_START, 32'd10);
      send_plan(ACT_INCREASE, '0, 32'h0000_4000, 32'h0100_0000, '0);
      send_tick();

      // random phases: runs of ticks ending in a plan request
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         min_v   = $urandom_range(0, 64);
         max_v   = $urandom_range(min_v, 1023);
         start_v = $urandom_range(0, 1023);
         case ($urandom_range(0, 4))
            0:       hold_v = '0;
            4:       hold_v = $urandom();
            default: hold_v = $urandom_range(1, 6);
         endcase
         case ($urandom_range(0, 2))
            0:       rt_v = RECOVER_TIME_RESET;
            1:       rt_v = $urandom_range(1 << 12, 1 << 20);
            default: rt_v = $urandom();
         endcase
         case (phase)
            0: begin
               min_v = 0;
               max_v = 1023;
            end
            1: begin
               min_v = 1023;
               max_v = 1023;
            end
            2: begin
               min_v = 0;
               max_v = 0;
            end
            3: begin
               min_v = $urandom_range(600, 1023);
               max_v = $urandom_range(0, 400);
            end
            4: hold_v = '1;
            5: rt_v = 32'd1;
            6: rt_v = '0;
            7: rt_v = '1;
            default: ;
         endcase
         if ($urandom_range(0, 2) == 0)
            csr_write(CSR_IDX_W'($urandom_range(CSR_SPARE_LO, CSR_SPARE_HI)), $urandom());
         csr_write(CSR_MIN, with_garbage(CW'(min_v)));
         csr_write(CSR_MAX, with_garbage(CW'(max_v)));
         csr_write(CSR_RECOVER, rt_v);
         csr_write(CSR_HOLD_OFF, hold_v);
         csr_write(CSR_START, with_garbage(CW'(start_v)));

         // no idling on either side in the closing phase
         last_phase   = (phase == RANDOM_PHASES - 1);
         stall_mode   = last_phase ? 0 : $urandom_range(0, 2);
         sender_idles = !last_phase && ($urandom_range(0, 3) != 0);
         tick_run_max = $urandom_range(0, 6);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            k = $urandom_range(0, tick_run_max);
            repeat (k) begin
               send_request(random_request(1'b0, 1'b1));
               sent++;
            end
            send_request(random_request(1'b1, $urandom_range(0, 9) == 0));
            sent++;
            // occasional pause until the block is empty
            if ($urandom_range(0, 60) == 0) drain_results();
         end
      end

      drain_results();
      plan_board.report_leftovers();
      $display("Covered %0d requests: %0d plans, %0d ticks, %0d register writes",
               plan_board.plans_seen + plan_board.ticks_seen, plan_board.plans_seen,
               plan_board.ticks_seen, plan_board.writes_seen);
      $display("Checked %0d results over %0d random phases, %0d held off, %0d mismatches",
               plan_board.results_seen, RANDOM_PHASES, plan_board.held_seen,
               plan_board.mismatches);
      if (plan_board.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
